[design/tln_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tln_pkg
// Shared types and constants of the transit line next-hop finder.
// ----------------------------------------------------------------------------
package tln_pkg;

  localparam int LINE_IDX_W = 4;
  localparam int SLOT_IDX_W = 5;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic       wr;
    logic       q_load;
    logic       sel_outer;
    logic       il_clr;
    logic       il_inc;
    logic       is_clr;
    logic       is_inc;
    logic       ol_clr;
    logic       ol_inc;
    logic       os_clr;
    logic       os_inc;
    logic       dir_init;
    logic       dir_line;
    logic       dir_step;
    logic       w_load;
    logic       b_load_w;
    logic       hit0_set;
    logic       hit1_set;
    logic       fsel;
    logic       fire;
    logic       found;
    logic       res_from;
    logic [1:0] changes;
  } tln_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic cur_in;
    logic il_last;
    logic ol_last;
    logic flag_i;
    logic eq_from;
    logic eq_to;
    logic eq_w;
    logic dir_hit;
    logic same;
  } tln_sts_t;

endpackage

[design/tln_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tln_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tln_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 512
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/tln_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tln_datapath
// Line table, scan cursors, route flags, direct-hop tracking and result
// registers, all driven by commands from the sequencer.
// ----------------------------------------------------------------------------
module tln_datapath #(
  parameter int MAX_LINES      = 16,
  parameter int SLOTS_PER_LINE = 32,
  parameter int NODE_ID_BITS   = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tln_pkg::tln_cmd_t             cmd,
  output tln_pkg::tln_sts_t             sts,
  input  logic [tln_pkg::LINE_IDX_W-1:0] in_line_index,
  input  logic [tln_pkg::SLOT_IDX_W-1:0] in_slot_index,
  input  logic [NODE_ID_BITS-1:0]       in_node_id,
  input  logic                          in_end_of_line,
  input  logic [NODE_ID_BITS-1:0]       in_from_node,
  input  logic [NODE_ID_BITS-1:0]       in_to_node,
  output logic                          out_valid,
  output logic                          out_found,
  output logic [NODE_ID_BITS-1:0]       out_next_node,
  output logic [1:0]                    out_changes
);
  import tln_pkg::*;

  localparam int LW    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int SW    = $clog2(SLOTS_PER_LINE);
  localparam int CW    = $clog2(SLOTS_PER_LINE + 1);
  localparam int DEPTH = MAX_LINES * SLOTS_PER_LINE;
  localparam int AW    = $clog2(DEPTH);

  logic [LW-1:0]           il_r, ol_r, cur_line;
  logic [CW-1:0]           is_r, os_r, cur_slot, len_cur;
  logic [CW-1:0]           len_r [MAX_LINES];
  logic [MAX_LINES-1:0]    hit0_r, hit1_r;
  logic [NODE_ID_BITS-1:0] from_r, to_r, b_r, w_r, nx_r, prev_r;
  logic                    seen_a_r, seen_b_r, pend_r, retp_r;
  logic [NODE_ID_BITS-1:0] rdata, nx_eff, dir_val;
  logic [AW-1:0]           raddr, waddr;
  logic                    wr_ok, ea, eb, more, dir_hit, dir_retp;

  assign wr_ok = cmd.wr && (32'(in_line_index) < MAX_LINES)
                 && (32'(in_slot_index) < SLOTS_PER_LINE);
  assign waddr = AW'(in_line_index) * AW'(SLOTS_PER_LINE) + AW'(in_slot_index);

  assign cur_line = cmd.sel_outer ? ol_r : il_r;
  assign cur_slot = cmd.sel_outer ? os_r : is_r;
  assign len_cur  = len_r[cur_line];
  assign raddr    = AW'(cur_line) * AW'(SLOTS_PER_LINE) + AW'(cur_slot[SW-1:0]);

  tln_ram #(
    .WIDTH(NODE_ID_BITS),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (wr_ok),
    .waddr(waddr),
    .wdata(in_node_id),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Direct-hop tracking for the slot just read on the inner cursor.
  assign ea     = (rdata == from_r);
  assign eb     = (rdata == b_r);
  assign more   = ((CW+1)'(is_r) + (CW+1)'(1)) < (CW+1)'(len_cur);
  assign nx_eff = pend_r ? rdata : nx_r;

  always_comb begin
    dir_hit  = 1'b0;
    dir_retp = 1'b0;
    dir_val  = nx_eff;
    if (retp_r) begin
      dir_hit = 1'b1;
      dir_val = rdata;
    end else if (ea && seen_b_r) begin
      dir_hit = 1'b1;
      dir_val = (is_r == '0) ? from_r : prev_r;
    end else if (eb && (seen_a_r || ea)) begin
      // When both ends are the same node, the hop is the following slot.
      if (ea && more) begin
        dir_retp = 1'b1;
      end else begin
        dir_hit = 1'b1;
      end
    end
  end

  assign sts.cur_in  = cur_slot < len_cur;
  assign sts.il_last = (il_r == LW'(MAX_LINES - 1));
  assign sts.ol_last = (ol_r == LW'(MAX_LINES - 1));
  assign sts.flag_i  = cmd.fsel ? hit1_r[il_r] : hit0_r[il_r];
  assign sts.eq_from = ea;
  assign sts.eq_to   = (rdata == to_r);
  assign sts.eq_w    = (rdata == w_r);
  assign sts.dir_hit = dir_hit;
  assign sts.same    = (from_r == to_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_LINES; i++) begin
        len_r[i] <= '0;
      end
      hit0_r    <= '0;
      hit1_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (wr_ok && in_end_of_line) begin
        len_r[LW'(in_line_index)] <= CW'(in_slot_index) + CW'(1);
      end
      if (cmd.q_load) begin
        hit0_r <= '0;
        hit1_r <= '0;
      end
      if (cmd.hit0_set) begin
        hit0_r[il_r] <= 1'b1;
      end
      if (cmd.hit1_set) begin
        hit1_r[ol_r] <= 1'b1;
      end
      out_valid <= cmd.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      from_r <= in_from_node;
      to_r   <= in_to_node;
      b_r    <= in_to_node;
    end
    if (cmd.b_load_w) begin
      b_r <= w_r;
    end
    if (cmd.w_load) begin
      w_r <= rdata;
    end
    if (cmd.il_clr) begin
      il_r <= '0;
    end else if (cmd.il_inc) begin
      il_r <= il_r + LW'(1);
    end
    if (cmd.is_clr) begin
      is_r <= '0;
    end else if (cmd.is_inc) begin
      is_r <= is_r + CW'(1);
    end
    if (cmd.ol_clr) begin
      ol_r <= '0;
    end else if (cmd.ol_inc) begin
      ol_r <= ol_r + LW'(1);
    end
    if (cmd.os_clr) begin
      os_r <= '0;
    end else if (cmd.os_inc) begin
      os_r <= os_r + CW'(1);
    end
    if (cmd.dir_init || cmd.dir_line) begin
      seen_a_r <= 1'b0;
      seen_b_r <= 1'b0;
      pend_r   <= 1'b0;
      retp_r   <= 1'b0;
    end else if (cmd.dir_step) begin
      seen_a_r <= seen_a_r | ea;
      seen_b_r <= seen_b_r | eb;
      pend_r   <= ea && more;
      retp_r   <= dir_retp;
      nx_r     <= nx_eff;
      prev_r   <= rdata;
    end
    if (cmd.dir_init) begin
      nx_r <= from_r;
    end
    if (cmd.fire) begin
      out_found     <= cmd.found;
      out_changes   <= cmd.found ? cmd.changes : 2'd0;
      out_next_node <= !cmd.found ? '0 : (cmd.res_from ? from_r : dir_val);
    end
  end

endmodule

[design/tln_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tln_ctrl
// Sequencer for the nested line scans: direct hop, target line flags,
// one-change search, two-change flags and two-change search.
// ----------------------------------------------------------------------------
module tln_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_mode,
  output logic              busy,
  output tln_pkg::tln_cmd_t cmd,
  input  tln_pkg::tln_sts_t sts
);
  import tln_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_QSTART = 5'd1;
  localparam logic [4:0] S_D_INIT = 5'd2;
  localparam logic [4:0] S_D_RD   = 5'd3;
  localparam logic [4:0] S_D_CHK  = 5'd4;
  localparam logic [4:0] S_H_INIT = 5'd5;
  localparam logic [4:0] S_H_RD   = 5'd6;
  localparam logic [4:0] S_H_CHK  = 5'd7;
  localparam logic [4:0] S_V_INIT = 5'd8;
  localparam logic [4:0] S_V_HRD  = 5'd9;
  localparam logic [4:0] S_V_HCHK = 5'd10;
  localparam logic [4:0] S_V_WRD  = 5'd11;
  localparam logic [4:0] S_V_WCHK = 5'd12;
  localparam logic [4:0] S_O_RD   = 5'd13;
  localparam logic [4:0] S_O_CHK  = 5'd14;
  localparam logic [4:0] S_K_INIT = 5'd15;
  localparam logic [4:0] S_K_RD   = 5'd16;
  localparam logic [4:0] S_K_CHK  = 5'd17;

  localparam logic [1:0] PH_DIR  = 2'd0;
  localparam logic [1:0] PH_VIA1 = 2'd1;
  localparam logic [1:0] PH_HIT1 = 2'd2;
  localparam logic [1:0] PH_VIA2 = 2'd3;

  logic [4:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [1:0] phase_changes;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    case (phase_r)
      PH_VIA1: phase_changes = 2'd1;
      PH_VIA2: phase_changes = 2'd2;
      default: phase_changes = 2'd0;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.fsel    = (phase_r == PH_VIA2);
    cmd.changes = phase_changes;
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_mode == MODE_QUERY) begin
            cmd.q_load = 1'b1;
            state_nxt  = S_QSTART;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_QSTART: begin
        phase_nxt = PH_DIR;
        if (sts.same) begin
          cmd.fire  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_D_INIT;
        end
      end
      S_D_INIT: begin
        cmd.il_clr   = 1'b1;
        cmd.is_clr   = 1'b1;
        cmd.dir_init = 1'b1;
        state_nxt    = S_D_RD;
      end
      S_D_RD: begin
        if (sts.cur_in) begin
          state_nxt = S_D_CHK;
        end else if (!sts.il_last) begin
          cmd.il_inc   = 1'b1;
          cmd.is_clr   = 1'b1;
          cmd.dir_line = 1'b1;
        end else if (phase_r == PH_DIR) begin
          state_nxt = S_H_INIT;
        end else begin
          // Transfer point without a direct line: stay at the source.
          cmd.fire     = 1'b1;
          cmd.found    = 1'b1;
          cmd.res_from = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_D_CHK: begin
        cmd.dir_step = 1'b1;
        if (sts.dir_hit) begin
          cmd.fire  = 1'b1;
          cmd.found = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.is_inc = 1'b1;
          state_nxt  = S_D_RD;
        end
      end
      S_H_INIT: begin
        cmd.il_clr = 1'b1;
        cmd.is_clr = 1'b1;
        state_nxt  = S_H_RD;
      end
      S_H_RD: begin
        if (sts.cur_in) begin
          state_nxt = S_H_CHK;
        end else if (sts.il_last) begin
          phase_nxt = PH_VIA1;
          state_nxt = S_V_INIT;
        end else begin
          cmd.il_inc = 1'b1;
          cmd.is_clr = 1'b1;
        end
      end
      S_H_CHK: begin
        if (sts.eq_to) begin
          cmd.hit0_set = 1'b1;
          if (sts.il_last) begin
            phase_nxt = PH_VIA1;
            state_nxt = S_V_INIT;
          end else begin
            cmd.il_inc = 1'b1;
            cmd.is_clr = 1'b1;
            state_nxt  = S_H_RD;
          end
        end else begin
          cmd.is_inc = 1'b1;
          state_nxt  = S_H_RD;
        end
      end
      S_V_INIT: begin
        cmd.ol_clr = 1'b1;
        cmd.os_clr = 1'b1;
        state_nxt  = S_V_HRD;
      end
      S_V_HRD, S_V_WRD: begin
        cmd.sel_outer = 1'b1;
        if (sts.cur_in) begin
          state_nxt = (state_r == S_V_HRD) ? S_V_HCHK : S_V_WCHK;
        end else if (!sts.ol_last) begin
          cmd.ol_inc = 1'b1;
          cmd.os_clr = 1'b1;
          state_nxt  = S_V_HRD;
        end else if (phase_r == PH_VIA1) begin
          phase_nxt = PH_HIT1;
          state_nxt = S_K_INIT;
        end else begin
          cmd.fire  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_V_HCHK: begin
        cmd.sel_outer = 1'b1;
        if (sts.eq_from) begin
          cmd.os_clr = 1'b1;
          state_nxt  = S_V_WRD;
        end else begin
          cmd.os_inc = 1'b1;
          state_nxt  = S_V_HRD;
        end
      end
      S_V_WCHK, S_K_CHK: begin
        cmd.sel_outer = 1'b1;
        cmd.w_load    = 1'b1;
        cmd.il_clr    = 1'b1;
        cmd.is_clr    = 1'b1;
        state_nxt     = S_O_RD;
      end
      S_O_RD: begin
        if (sts.flag_i && sts.cur_in) begin
          state_nxt = S_O_CHK;
        end else if (!sts.il_last) begin
          cmd.il_inc = 1'b1;
          cmd.is_clr = 1'b1;
        end else begin
          cmd.os_inc = 1'b1;
          state_nxt  = (phase_r == PH_HIT1) ? S_K_RD : S_V_WRD;
        end
      end
      S_O_CHK: begin
        if (!sts.eq_w) begin
          cmd.is_inc = 1'b1;
          state_nxt  = S_O_RD;
        end else if (phase_r != PH_HIT1) begin
          cmd.b_load_w = 1'b1;
          state_nxt    = S_D_INIT;
        end else begin
          cmd.hit1_set = 1'b1;
          if (sts.ol_last) begin
            phase_nxt = PH_VIA2;
            state_nxt = S_V_INIT;
          end else begin
            cmd.ol_inc = 1'b1;
            cmd.os_clr = 1'b1;
            state_nxt  = S_K_RD;
          end
        end
      end
      S_K_INIT: begin
        cmd.ol_clr = 1'b1;
        cmd.os_clr = 1'b1;
        state_nxt  = S_K_RD;
      end
      S_K_RD: begin
        cmd.sel_outer = 1'b1;
        if (sts.cur_in) begin
          state_nxt = S_K_CHK;
        end else if (sts.ol_last) begin
          phase_nxt = PH_VIA2;
          state_nxt = S_V_INIT;
        end else begin
          cmd.ol_inc = 1'b1;
          cmd.os_clr = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_DIR;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

[design/transit_line_next_hop.sv]
`timescale 1ns / 1ps
// A write item leaves busy low, and the next item may follow at once.
// A query visits the table slots one at a time, through the one read port of the
// slot RAM; its result strobes out_valid for one cycle as busy falls.
// Reset empties every line at once; slot contents are undefined until written.
// ----------------------------------------------------------------------------
// transit_line_next_hop
// Next-hop finder over a table of transit lines, with up to two changes.
// ----------------------------------------------------------------------------
module transit_line_next_hop #(
  parameter int MAX_LINES      = 16,
  parameter int SLOTS_PER_LINE = 32,
  parameter int NODE_ID_BITS   = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_mode,
  input  logic [tln_pkg::LINE_IDX_W-1:0] in_line_index,
  input  logic [tln_pkg::SLOT_IDX_W-1:0] in_slot_index,
  input  logic [NODE_ID_BITS-1:0]        in_node_id,
  input  logic                           in_end_of_line,
  input  logic [NODE_ID_BITS-1:0]        in_from_node,
  input  logic [NODE_ID_BITS-1:0]        in_to_node,
  output logic                           out_valid,
  output logic                           out_found,
  output logic [NODE_ID_BITS-1:0]        out_next_node,
  output logic [1:0]                     out_changes
);
  import tln_pkg::*;

  tln_cmd_t cmd;
  tln_sts_t sts;

  tln_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_mode(in_mode),
    .busy   (busy),
    .cmd    (cmd),
    .sts    (sts)
  );

  tln_datapath #(
    .MAX_LINES     (MAX_LINES),
    .SLOTS_PER_LINE(SLOTS_PER_LINE),
    .NODE_ID_BITS  (NODE_ID_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_line_index (in_line_index),
    .in_slot_index (in_slot_index),
    .in_node_id    (in_node_id),
    .in_end_of_line(in_end_of_line),
    .in_from_node  (in_from_node),
    .in_to_node    (in_to_node),
    .out_valid     (out_valid),
    .out_found     (out_found),
    .out_next_node (out_next_node),
    .out_changes   (out_changes)
  );

endmodule

[design/tln_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tln_checker
// Port-level checks of the next-hop finder, bound to the top level.
// ----------------------------------------------------------------------------
module tln_checker #(
  parameter int NODE_ID_BITS = 10
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           in_mode,
  input logic                           out_valid,
  input logic                           out_found,
  input logic [NODE_ID_BITS-1:0]        out_next_node,
  input logic [1:0]                     out_changes
);
  import tln_pkg::*;

  // A result appears only when the query has finished.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_next_node == '0 && out_changes == 2'd0))
    else $error("not-found result carries data");

  a_changes_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_changes != 2'd3))
    else $error("change count out of range");

  a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_WRITE) |=> !busy)
    else $error("write item made the block busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

endmodule

bind transit_line_next_hop tln_checker #(.NODE_ID_BITS(NODE_ID_BITS)) u_chk (.*);
